// File: sv/mdvco_pkg.sv
// ----------------------------------------------------------------------------
// mdvco_pkg
// Shared types, codes, constants and helper functions of the MIDI note to
// dual VCO PWM core.
// ----------------------------------------------------------------------------
package mdvco_pkg;

   // held-key table geometry
   localparam int KEY_SLOTS = 8;
   localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   // field widths
   localparam int NOTE_W     = 7;
   localparam int BYTE_W     = 8;
   localparam int PWM_W      = 16;
   localparam int TAB_W      = 10;
   localparam int TUNE_W     = 10;
   localparam int SHIFT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LISTEN_CHANNEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_MODE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_SHIFT_ONE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_SHIFT_TWO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_TUNE_ONE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_TUNE_TWO    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LFO_SYNC_ENABLE  = 3'd6;

   // voice modes (sequencer mode acts as last key)
   localparam logic [1:0] MODE_LAST = 2'd0;
   localparam logic [1:0] MODE_LOW  = 2'd1;
   localparam logic [1:0] MODE_DUAL = 2'd2;
   localparam logic [1:0] MODE_SEQ  = 2'd3;

   // MIDI commands (upper status nibble)
   localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

   // octave shift codes
   localparam logic [SHIFT_W-1:0] OCT_DOWN_TWO = 3'd0;
   localparam logic [SHIFT_W-1:0] OCT_DOWN_ONE = 3'd1;
   localparam logic [SHIFT_W-1:0] OCT_NONE     = 3'd2;
   localparam logic [SHIFT_W-1:0] OCT_UP_ONE   = 3'd3;
   localparam logic [SHIFT_W-1:0] OCT_UP_TWO   = 3'd4;

   // note range and scale split
   localparam logic [BYTE_W-1:0] NOTE_LOW    = 8'd36;
   localparam logic [BYTE_W-1:0] NOTE_HIGH   = 8'd96;
   localparam logic [NOTE_W-1:0] RANGE_SPLIT = 7'd66;
   localparam logic [PWM_W-1:0]  PWM_RESET   = 16'd270;

   // PWM compare table, four semitones between interpolation points
   localparam logic [TAB_W-1:0] PWM_TABLE [66] = '{
      10'd953, 10'd942, 10'd936, 10'd926, 10'd916, 10'd903, 10'd893, 10'd882,
      10'd866, 10'd850, 10'd838, 10'd822, 10'd810, 10'd790, 10'd772, 10'd753,
      10'd734, 10'd707, 10'd685, 10'd659, 10'd635, 10'd611, 10'd580, 10'd550,
      10'd512, 10'd475, 10'd446, 10'd405, 10'd366, 10'd316, 10'd270, 10'd929,
      10'd919, 10'd909, 10'd900, 10'd888, 10'd873, 10'd859, 10'd844, 10'd831,
      10'd815, 10'd796, 10'd777, 10'd760, 10'd738, 10'd717, 10'd696, 10'd670,
      10'd648, 10'd620, 10'd590, 10'd560, 10'd530, 10'd493, 10'd457, 10'd420,
      10'd382, 10'd335, 10'd290, 10'd245, 10'd200, 10'd160, 10'd120, 10'd80,
      10'd40,  10'd0
   };

   // byte parser phase
   typedef enum logic [1:0] {
      PH_STATUS,
      PH_NOTE,
      PH_VELOCITY
   } parse_phase_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PITCH_ONE,
      ST_PITCH_TWO,
      ST_PITCH_WAIT,
      ST_DONE
   } fsm_state_type;

   // key table commands
   typedef struct packed {
      logic scan_go;
      logic note_off;
      logic store;
      logic free;
   } key_cmd_type;

   // key table scan results
   typedef struct packed {
      logic              done;
      logic              have_held;
      logic [NOTE_W-1:0] low_note;
      logic [NOTE_W-1:0] high_note;
      logic              free_found;
      logic              match_found;
   } key_stat_type;

   // pitch unit request and result
   typedef struct packed {
      logic                      valid;
      logic                      sel_two;
      logic [SHIFT_W-1:0]        shift;
      logic signed [TUNE_W-1:0]  tune;
      logic [NOTE_W-1:0]         note;
   } pitch_req_type;

   typedef struct packed {
      logic             valid;
      logic             sel_two;
      logic [PWM_W-1:0] pwm;
      logic             range;
   } pitch_rsp_type;

   // octave shift, skipped when the shifted note would leave 36..96
   function automatic logic [NOTE_W-1:0] shift_octave(input logic [SHIFT_W-1:0] sel,
                                                      input logic [NOTE_W-1:0] n);
      logic [NOTE_W-1:0] r;
      r = n;
      unique case (sel)
         OCT_DOWN_TWO: if (n >= 7'd60) r = n - 7'd24;
         OCT_DOWN_ONE: if (n >= 7'd48) r = n - 7'd12;
         OCT_UP_ONE:   if (n <= 7'd84) r = n + 7'd12;
         OCT_UP_TWO:   if (n <= 7'd72) r = n + 7'd24;
         default:      r = n;
      endcase
      return r;
   endfunction

endpackage

// File: sv/mdvco_keys.sv
// ----------------------------------------------------------------------------
// mdvco_keys
// Held-key table: note memory with registered read, used bits, and a scan
// engine that finds the lowest and highest held notes, the first free slot
// and the first slot matching a released note.
// ----------------------------------------------------------------------------
module mdvco_keys import mdvco_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  key_cmd_type       cmd,
   input  logic [BYTE_W-1:0] note,
   output key_stat_type      stat
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

   logic [NOTE_W-1:0]    mem [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] used_ff;
   logic [KEY_SLOTS-1:0] used_in;

   logic [SLOT_W-1:0]    rd_addr_ff;
   logic                 issue_ff;
   logic                 off_ff;
   logic                 proc_valid_ff;
   logic [SLOT_W-1:0]    proc_idx_ff;
   logic [NOTE_W-1:0]    rd_data_ff;
   logic                 done_ff;

   logic                 have_ff;
   logic [NOTE_W-1:0]    low_ff;
   logic [NOTE_W-1:0]    high_ff;
   logic                 free_found_ff;
   logic [SLOT_W-1:0]    free_idx_ff;
   logic                 match_found_ff;
   logic [SLOT_W-1:0]    match_idx_ff;

   // read address sweep, one slot per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= 1'b0;
         rd_addr_ff <= '0;
         off_ff     <= 1'b0;
      end else if (cmd.scan_go) begin
         issue_ff   <= 1'b1;
         rd_addr_ff <= '0;
         off_ff     <= cmd.note_off;
      end else if (issue_ff) begin
         if (rd_addr_ff == LAST_SLOT) begin
            issue_ff <= 1'b0;
         end else begin
            rd_addr_ff <= rd_addr_ff + 1'b1;
         end
      end
   end

   // note memory: registered read, single write port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr_ff];
      if (cmd.store && free_found_ff) begin
         mem[free_idx_ff] <= note[NOTE_W-1:0];
      end
   end

   // read data stage tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         proc_valid_ff <= issue_ff;
         done_ff       <= proc_valid_ff && (proc_idx_ff == LAST_SLOT);
      end
      proc_idx_ff <= rd_addr_ff;
   end

   // used bits: set on store, cleared on release
   always_comb begin
      used_in = used_ff;
      if (cmd.store && free_found_ff) begin
         used_in[free_idx_ff] = 1'b1;
      end
      if (cmd.free && match_found_ff) begin
         used_in[match_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // scan accumulators; the first matching slot is left out of low/high
   always_ff @(posedge clock) begin
      if (cmd.scan_go) begin
         have_ff        <= 1'b0;
         low_ff         <= '1;
         high_ff        <= '0;
         free_found_ff  <= 1'b0;
         free_idx_ff    <= '0;
         match_found_ff <= 1'b0;
         match_idx_ff   <= '0;
      end else if (proc_valid_ff) begin
         if (!used_ff[proc_idx_ff]) begin
            if (!free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= proc_idx_ff;
            end
         end else if (off_ff && !match_found_ff && ({1'b0, rd_data_ff} == note)) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= proc_idx_ff;
         end else begin
            have_ff <= 1'b1;
            if (!have_ff || (rd_data_ff < low_ff)) begin
               low_ff <= rd_data_ff;
            end
            if (!have_ff || (rd_data_ff > high_ff)) begin
               high_ff <= rd_data_ff;
            end
         end
      end
   end

   assign stat.done        = done_ff;
   assign stat.have_held   = have_ff;
   assign stat.low_note    = low_ff;
   assign stat.high_note   = high_ff;
   assign stat.free_found  = free_found_ff;
   assign stat.match_found = match_found_ff;

endmodule

// File: sv/mdvco_pitch.sv
// ----------------------------------------------------------------------------
// mdvco_pitch
// Three-stage pitch unit: octave shift and table lookup, tune multiply,
// then truncating divide by 512 and add to the base entry.
// ----------------------------------------------------------------------------
module mdvco_pitch import mdvco_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  pitch_req_type req,
   output pitch_rsp_type rsp
);

   localparam int DIFF_W = TAB_W + 1;
   localparam int PROD_W = TUNE_W + DIFF_W;
   localparam int DLT_W  = PROD_W - 9;

   logic [NOTE_W-1:0] shifted;
   logic [NOTE_W-1:0] k;
   logic [NOTE_W-1:0] idx_lo;
   logic [NOTE_W-1:0] idx_hi;
   logic [TAB_W-1:0]  tab_lo;
   logic [TAB_W-1:0]  tab_hi;

   logic                     a_valid_ff;
   logic                     a_sel_ff;
   logic                     a_range_ff;
   logic [TAB_W-1:0]         a_base_ff;
   logic signed [DIFF_W-1:0] a_diff_ff;
   logic signed [TUNE_W-1:0] a_tune_ff;

   logic                     b_valid_ff;
   logic                     b_sel_ff;
   logic                     b_range_ff;
   logic [TAB_W-1:0]         b_base_ff;
   logic signed [PROD_W-1:0] b_prod_ff;

   logic signed [PROD_W-1:0] adj;
   logic [DLT_W-1:0]         delta;

   logic                     c_valid_ff;
   logic                     c_sel_ff;
   logic                     c_range_ff;
   logic [PWM_W-1:0]         c_pwm_ff;

   // table index, clamped; mid-scale notes share the 26..30 span
   always_comb begin
      shifted = shift_octave(req.shift, req.note);
      k       = (shifted >= NOTE_LOW[NOTE_W-1:0]) ? shifted - NOTE_LOW[NOTE_W-1:0] : '0;
      if (k > 7'd61) begin
         k = 7'd61;
      end
      if ((k > 7'd26) && (k < 7'd31)) begin
         idx_lo = 7'd26;
         idx_hi = 7'd30;
      end else begin
         idx_lo = k;
         idx_hi = k + 7'd4;
      end
      tab_lo = PWM_TABLE[idx_lo];
      tab_hi = PWM_TABLE[idx_hi];
   end

   // stage A: lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= req.valid;
      end
      a_sel_ff   <= req.sel_two;
      a_range_ff <= (shifted > RANGE_SPLIT);
      a_base_ff  <= PWM_TABLE[k];
      a_diff_ff  <= $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});
      a_tune_ff  <= req.tune;
   end

   // stage B: multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_sel_ff   <= a_sel_ff;
      b_range_ff <= a_range_ff;
      b_base_ff  <= a_base_ff;
      b_prod_ff  <= a_tune_ff * a_diff_ff;
   end

   // stage C: divide by 512 toward zero, add base, wrap
   always_comb begin
      adj   = b_prod_ff + (b_prod_ff[PROD_W-1] ? PROD_W'(511) : PROD_W'(0));
      delta = adj[PROD_W-1:9];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_sel_ff   <= b_sel_ff;
      c_range_ff <= b_range_ff;
      c_pwm_ff   <= PWM_W'(b_base_ff) + {{(PWM_W - DLT_W){delta[DLT_W-1]}}, delta};
   end

   assign rsp.valid   = c_valid_ff;
   assign rsp.sel_two = c_sel_ff;
   assign rsp.pwm     = c_pwm_ff;
   assign rsp.range   = c_range_ff;

endmodule

// File: sv/midi_note_to_dual_vco_pwm_core.sv
// ----------------------------------------------------------------------------
// midi_note_to_dual_vco_pwm_core
// MIDI byte parser and note sequencer driving two VCO PWM compare values.
//
//   channel  ports                         handshake
//   input    req_midi_byte                 start, busy
//   result   rsp_gate_on .. rsp_range_two  rsp_valid strobe, one cycle
//   config   csr_index, csr_data           csr_write_enable
//
// Status and note bytes are accepted while busy stays low.
// A third byte of an ignored message gives its result in the next cycle.
// A note message scans the key memory, one slot per cycle through its read
// port, then may send pitch requests for VCO one and VCO two and wait for
// the second result. Busy stays high through the result cycle.
// Reset is synchronous and needs no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module midi_note_to_dual_vco_pwm_core import mdvco_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [BYTE_W-1:0]     req_midi_byte,
   output logic                  rsp_valid,
   output logic                  rsp_gate_on,
   output logic                  rsp_strike,
   output logic                  rsp_lfo_restart,
   output logic [PWM_W-1:0]      rsp_pwm_one,
   output logic [PWM_W-1:0]      rsp_pwm_two,
   output logic                  rsp_range_one,
   output logic                  rsp_range_two,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [3:0]               listen_channel_ff;
   logic [1:0]               voice_mode_ff;
   logic [SHIFT_W-1:0]       octave_shift_one_ff;
   logic [SHIFT_W-1:0]       octave_shift_two_ff;
   logic signed [TUNE_W-1:0] fine_tune_one_ff;
   logic signed [TUNE_W-1:0] fine_tune_two_ff;
   logic                     lfo_sync_enable_ff;

   // parser and voice state
   parse_phase_type   parse_phase_ff;
   logic [BYTE_W-1:0] held_status_ff;
   logic [BYTE_W-1:0] held_note_ff;
   fsm_state_type     state_ff;
   fsm_state_type     state_in;
   logic              gate_ff;
   logic              strike_ff;
   logic              lfo_restart_ff;
   logic [PWM_W-1:0]  pwm_one_ff;
   logic [PWM_W-1:0]  pwm_two_ff;
   logic              range_one_ff;
   logic              range_two_ff;
   logic [NOTE_W-1:0] vco_note_one_ff;
   logic [NOTE_W-1:0] vco_note_two_ff;
   logic [NOTE_W-1:0] vco_note_one_in;
   logic [NOTE_W-1:0] vco_note_two_in;

   logic              accept;
   logic              chan_ok;
   logic              is_on;
   logic              is_off;
   logic              play;
   logic [NOTE_W-1:0] note7;
   logic [NOTE_W-1:0] post_high;
   logic [NOTE_W-1:0] post_low;

   logic              vco_load;
   logic              gate_set;
   logic              gate_clear;
   logic              msg_start;

   key_cmd_type       key_cmd;
   key_stat_type      key_stat;
   pitch_req_type     pitch_req;
   pitch_rsp_type     pitch_rsp;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff   <= '0;
         voice_mode_ff       <= MODE_LAST;
         octave_shift_one_ff <= OCT_NONE;
         octave_shift_two_ff <= OCT_NONE;
         fine_tune_one_ff    <= '0;
         fine_tune_two_ff    <= '0;
         lfo_sync_enable_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LISTEN_CHANNEL:   listen_channel_ff   <= csr_data[3:0];
            CSR_VOICE_MODE:       voice_mode_ff       <= csr_data[1:0];
            CSR_OCTAVE_SHIFT_ONE: octave_shift_one_ff <= csr_data[SHIFT_W-1:0];
            CSR_OCTAVE_SHIFT_TWO: octave_shift_two_ff <= csr_data[SHIFT_W-1:0];
            CSR_FINE_TUNE_ONE:    fine_tune_one_ff    <= $signed(csr_data[TUNE_W-1:0]);
            CSR_FINE_TUNE_TWO:    fine_tune_two_ff    <= $signed(csr_data[TUNE_W-1:0]);
            CSR_LFO_SYNC_ENABLE:  lfo_sync_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // byte grouping: status, note, velocity
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff <= PH_STATUS;
         held_status_ff <= '0;
         held_note_ff   <= '0;
      end else if (accept) begin
         unique case (parse_phase_ff)
            PH_STATUS: begin
               held_status_ff <= req_midi_byte;
               parse_phase_ff <= PH_NOTE;
            end
            PH_NOTE: begin
               held_note_ff   <= req_midi_byte;
               parse_phase_ff <= PH_VELOCITY;
            end
            default: parse_phase_ff <= PH_STATUS;
         endcase
      end
   end

   // message decode and note selection
   always_comb begin
      note7   = held_note_ff[NOTE_W-1:0];
      chan_ok = (held_status_ff[3:0] == listen_channel_ff);
      is_on   = chan_ok && (held_status_ff[7:4] == CMD_NOTE_ON) &&
                (held_note_ff >= NOTE_LOW) && (held_note_ff <= NOTE_HIGH);
      is_off  = chan_ok && (held_status_ff[7:4] == CMD_NOTE_OFF);
      play    = !((voice_mode_ff == MODE_LOW) && key_stat.have_held &&
                  (held_note_ff > {1'b0, key_stat.low_note}));
      // highest and lowest after the new note is stored
      if (!key_stat.have_held) begin
         post_high = note7;
         post_low  = note7;
      end else if (key_stat.free_found) begin
         post_high = (key_stat.high_note > note7) ? key_stat.high_note : note7;
         post_low  = (key_stat.low_note < note7) ? key_stat.low_note : note7;
      end else begin
         post_high = key_stat.high_note;
         post_low  = key_stat.low_note;
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      key_cmd          = '0;
      msg_start        = 1'b0;
      vco_load         = 1'b0;
      gate_set         = 1'b0;
      gate_clear       = 1'b0;
      vco_note_one_in  = note7;
      vco_note_two_in  = note7;
      pitch_req.valid   = 1'b0;
      pitch_req.sel_two = 1'b0;
      pitch_req.shift   = octave_shift_one_ff;
      pitch_req.tune    = fine_tune_one_ff;
      pitch_req.note    = vco_note_one_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (parse_phase_ff == PH_VELOCITY)) begin
               msg_start = 1'b1;
               if (is_on || is_off) begin
                  key_cmd.scan_go  = 1'b1;
                  key_cmd.note_off = is_off;
                  state_in         = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (key_stat.done) begin
               state_in = ST_DONE;
               if (is_on) begin
                  key_cmd.store = 1'b1;
                  if (play) begin
                     gate_set = 1'b1;
                     vco_load = 1'b1;
                     state_in = ST_PITCH_ONE;
                     if (voice_mode_ff == MODE_DUAL) begin
                        vco_note_one_in = post_high;
                        vco_note_two_in = post_low;
                     end
                  end
               end else if (key_stat.match_found) begin
                  key_cmd.free = 1'b1;
                  if (!key_stat.have_held) begin
                     gate_clear = 1'b1;
                  end else if (voice_mode_ff == MODE_LOW) begin
                     vco_load        = 1'b1;
                     vco_note_one_in = key_stat.low_note;
                     vco_note_two_in = key_stat.low_note;
                     state_in        = ST_PITCH_ONE;
                  end
               end
            end
         end
         ST_PITCH_ONE: begin
            pitch_req.valid = 1'b1;
            state_in        = ST_PITCH_TWO;
         end
         ST_PITCH_TWO: begin
            pitch_req.valid   = 1'b1;
            pitch_req.sel_two = 1'b1;
            pitch_req.shift   = octave_shift_two_ff;
            pitch_req.tune    = fine_tune_two_ff;
            pitch_req.note    = vco_note_two_ff;
            state_in          = ST_PITCH_WAIT;
         end
         ST_PITCH_WAIT: begin
            if (pitch_rsp.valid && pitch_rsp.sel_two) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // voice registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff        <= 1'b0;
         strike_ff      <= 1'b0;
         lfo_restart_ff <= 1'b0;
         pwm_one_ff     <= PWM_RESET;
         pwm_two_ff     <= PWM_RESET;
         range_one_ff   <= 1'b1;
         range_two_ff   <= 1'b1;
      end else begin
         if (msg_start) begin
            strike_ff      <= 1'b0;
            lfo_restart_ff <= 1'b0;
         end
         if (gate_set) begin
            gate_ff        <= 1'b1;
            strike_ff      <= 1'b1;
            lfo_restart_ff <= lfo_sync_enable_ff;
         end
         if (gate_clear) begin
            gate_ff <= 1'b0;
         end
         if (pitch_rsp.valid) begin
            if (pitch_rsp.sel_two) begin
               pwm_two_ff   <= pitch_rsp.pwm;
               range_two_ff <= pitch_rsp.range;
            end else begin
               pwm_one_ff   <= pitch_rsp.pwm;
               range_one_ff <= pitch_rsp.range;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vco_load) begin
         vco_note_one_ff <= vco_note_one_in;
         vco_note_two_ff <= vco_note_two_in;
      end
   end

   mdvco_keys u_keys (
      .clock (clock),
      .reset (reset),
      .cmd   (key_cmd),
      .note  (held_note_ff),
      .stat  (key_stat)
   );

   mdvco_pitch u_pitch (
      .clock (clock),
      .reset (reset),
      .req   (pitch_req),
      .rsp   (pitch_rsp)
   );

   // result ports
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_gate_on     = gate_ff;
   assign rsp_strike      = strike_ff;
   assign rsp_lfo_restart = lfo_restart_ff;
   assign rsp_pwm_one     = pwm_one_ff;
   assign rsp_pwm_two     = pwm_two_ff;
   assign rsp_range_one   = range_one_ff;
   assign rsp_range_two   = range_two_ff;

   // checks
   a_result_after_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (parse_phase_ff == PH_STATUS))
      else $error("result outside a completed message");

   a_strike_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strike |-> rsp_gate_on)
      else $error("strike without gate");

   a_busy_from_velocity: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && ($past(parse_phase_ff) == PH_VELOCITY))
      else $error("busy raised without a third byte");

   a_pitch_in_window: assert property (@(posedge clock) disable iff (reset)
      pitch_rsp.valid |-> (state_ff == ST_PITCH_TWO) || (state_ff == ST_PITCH_WAIT))
      else $error("pitch result outside pitch phase");

endmodule
